// File: hw/rtl/sle_pkg.sv
// Shared types and codes of the sorted list engine.
package sle_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OCC_WIDTH   = 5;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_DUMP_FWD = 2'd2,
    OP_DUMP_REV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    op_t    op;
    value_t value;
  } in_item_t;

  typedef struct packed {
    value_t                 entry_value;
    logic [OCC_WIDTH-1:0]   occupancy;
    status_t                status;
    logic                   last;
  } out_item_t;

  // Result of comparing one stored entry with the operand.
  typedef struct packed {
    logic goes_before;
    logic walk_past;
    logic equal;
  } cmp_t;

  // Byte address of the mode register.
  localparam logic [2:0] ADDR_MODE = 3'd0;

endpackage

// File: hw/rtl/sle_cmp.sv
// Signed order compare between a stored entry and the operand.
module sle_cmp
  import sle_pkg::*;
(
  input  value_t entry,
  input  value_t operand,
  input  logic   descending,
  output cmp_t   res
);

  logic lt;
  logic eq;
  logic e_le_v;
  logic v_le_e;

  assign lt     = entry < operand;
  assign eq     = entry == operand;
  assign e_le_v = lt | eq;
  assign v_le_e = ~lt;

  // The operand belongs at or before the entry, or the walk may step past it.
  assign res.goes_before = descending ? e_le_v : v_le_e;
  assign res.walk_past   = descending ? v_le_e : e_le_v;
  assign res.equal       = eq;

endmodule

// File: hw/rtl/sorted_list_engine.sv
// Top level of the sorted list engine: sequencer, entry memory and register port.
//
//   Channel  Dir     Handshake                             Payload
//   input    in      start, busy; taken on start & !busy   in_item (op, value)
//   result   out     out_valid strobe for one cycle        out_item (entry_value, occupancy,
//                                                                    status, last)
//   config   in/out  APB psel, penable, pwrite; pready 1   descending_mode at byte address 0
//
// Insert, delete and forward dump walk the entries from the head, a reverse dump
// from the tail, through the one memory read port, one entry per cycle (a dump
// sends a result per entry); a new item is taken only once the walk is done. An insert
// into a full store, a delete from an empty store and a dump of an empty store answer
// in the next cycle. Reset (rst_n, synchronous, active low) empties the store and clears
// the mode. The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,

  output logic        out_valid,
  output out_item_t   out_item,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // AW indexes the memory; IW also holds the count itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // Entry memory: one write port, one registered read port.
  value_t          mem [CAPACITY];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  value_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  value_t          rdata_r;

  state_t          state_r,     state_nxt;
  op_t             op_r,        op_nxt;
  value_t          val_r,       val_nxt;
  logic [IW-1:0]   cnt_r,       cnt_nxt;
  logic [IW-1:0]   rd_idx_r,    rd_idx_nxt;
  logic [IW-1:0]   pj_r,        pj_nxt;
  logic            pv_r,        pv_nxt;
  logic            found_r,     found_nxt;
  value_t          carry_r,     carry_nxt;
  logic            mode_r,      mode_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r,  out_item_nxt;

  logic            accept;
  logic            issue;
  logic            hit;
  logic [IW-1:0]   rev_idx;
  logic [IW-1:0]   cnt_m1;
  logic [IW-1:0]   pj_m1;
  cmp_t            cmp;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == ADDR_MODE[2]) ? {31'd0, mode_r} : 32'd0;

  // The one comparator that every search step shares.
  sle_cmp u_cmp (
    .entry      (rdata_r),
    .operand    (val_r),
    .descending (mode_r),
    .res        (cmp)
  );

  assign cnt_m1  = cnt_r - IW'(1);
  assign pj_m1   = pj_r - IW'(1);
  assign rev_idx = cnt_m1 - rd_idx_r;
  assign issue   = (rd_idx_r != cnt_r);
  // Position found: before the head, or at the first entry the walk stops on.
  assign hit     = (pj_r == '0) ? cmp.goes_before : ~cmp.walk_past;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pj_nxt        = pj_r;
    pv_nxt        = 1'b0;
    found_nxt     = found_r;
    carry_nxt     = carry_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = pj_r[AW-1:0];
    mem_wdata     = carry_r;
    mem_re        = 1'b0;
    mem_raddr     = (op_r == OP_DUMP_REV) ? rev_idx[AW-1:0] : rd_idx_r[AW-1:0];

    if (psel && penable && pwrite && (paddr[2] == ADDR_MODE[2])) begin
      mode_nxt = pwdata[0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_item.op;
          val_nxt    = in_item.value;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          out_item_nxt.entry_value = in_item.value;
          out_item_nxt.occupancy   = OCC_WIDTH'(cnt_r);
          out_item_nxt.last        = 1'b1;
          unique case (in_item.op) inside
            OP_INSERT: begin
              if (cnt_r == IW'(CAPACITY)) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = STAT_FULL;
              end else begin
                state_nxt = S_RUN;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = STAT_EMPTY;
              end else begin
                state_nxt = S_RUN;
              end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              if (cnt_r == '0) begin
                out_valid_nxt            = 1'b1;
                out_item_nxt.entry_value = '0;
                out_item_nxt.status      = STAT_EMPTY;
              end else begin
                state_nxt = S_RUN;
              end
            end
          endcase
        end
      end

      S_RUN: begin
        // Read stage: fetch the next entry while the previous one is handled.
        if (issue) begin
          mem_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + IW'(1);
          pv_nxt     = 1'b1;
          pj_nxt     = rd_idx_r;
        end

        if (pv_r) begin
          unique case (op_r) inside
            OP_INSERT: begin
              // Once the slot is found, every later entry moves up by one.
              if (found_r) begin
                mem_we    = 1'b1;
                mem_wdata = carry_r;
                carry_nxt = rdata_r;
              end else if (hit) begin
                mem_we    = 1'b1;
                mem_wdata = val_r;
                carry_nxt = rdata_r;
                found_nxt = 1'b1;
              end
            end
            OP_DELETE: begin
              // After the first match, every later entry moves down by one.
              if (found_r) begin
                mem_we    = 1'b1;
                mem_waddr = pj_m1[AW-1:0];
                mem_wdata = rdata_r;
              end else if (cmp.equal) begin
                found_nxt = 1'b1;
              end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              out_valid_nxt            = 1'b1;
              out_item_nxt.entry_value = rdata_r;
              out_item_nxt.occupancy   = OCC_WIDTH'(cnt_r);
              out_item_nxt.status      = STAT_OK;
              out_item_nxt.last        = (pj_r == cnt_m1);
            end
          endcase
        end else if (!issue) begin
          // Final step after the last entry has been handled.
          state_nxt = S_IDLE;
          unique case (op_r) inside
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = cnt_r[AW-1:0];
              mem_wdata = found_r ? carry_r : val_r;
              cnt_nxt   = cnt_r + IW'(1);
              out_valid_nxt            = 1'b1;
              out_item_nxt.entry_value = val_r;
              out_item_nxt.occupancy   = OCC_WIDTH'(cnt_r + IW'(1));
              out_item_nxt.status      = STAT_OK;
              out_item_nxt.last        = 1'b1;
            end
            OP_DELETE: begin
              cnt_nxt = found_r ? cnt_m1 : cnt_r;
              out_valid_nxt            = 1'b1;
              out_item_nxt.entry_value = val_r;
              out_item_nxt.occupancy   = OCC_WIDTH'(found_r ? cnt_m1 : cnt_r);
              out_item_nxt.status      = found_r ? STAT_OK : STAT_NOTFOUND;
              out_item_nxt.last        = 1'b1;
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              // Every entry has already been sent.
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pj_r       <= pj_nxt;
    found_r    <= found_nxt;
    carry_r    <= carry_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule

// File: tb/sorted_list_engine_checker.sv
// Checker of the sorted list engine: watches every channel, predicts the results and compares.
`timescale 1ns / 1ps
module sorted_list_engine_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_owed,
  output int          entries_held
);

  value_t    entries [CAPACITY];
  int        held = 0;
  logic      descending = 1'b0;
  out_item_t owed_results [$];
  out_item_t want;
  int        errors = 0;

  // True when the operand belongs before or at entry e in the current order.
  function automatic logic lands_ahead(value_t e, value_t v);
    return descending ? (e <= v) : (v <= e);
  endfunction

  // True when the insertion walk may step past entry e.
  function automatic logic steps_past(value_t e, value_t v);
    return descending ? (v <= e) : (e <= v);
  endfunction

  task automatic flag(string what);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic owe(value_t v, status_t st, logic fin);
    owed_results.push_back('{entry_value: v, occupancy: OCC_WIDTH'(held), status: st,
                             last: fin});
  endtask

  task automatic predict_item(in_item_t item);
    int      pos;
    int      i;
    logic    hit;
    status_t st;
    value_t  v;
    v = item.value;
    case (item.op)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          if (held == 0 || lands_ahead(entries[0], v)) begin
            pos = 0;
          end else begin
            i = 0;
            while (i + 1 < held && steps_past(entries[i + 1], v)) i++;
            pos = i + 1;
          end
          for (i = held; i > pos; i--) entries[i] = entries[i - 1];
          entries[pos] = v;
          held++;
          st = STAT_OK;
        end
        owe(v, st, 1'b1);
      end
      OP_DELETE: begin
        if (held == 0) begin
          st = STAT_EMPTY;
        end else begin
          hit = 1'b0;
          pos = 0;
          for (i = 0; i < held && !hit; i++) begin
            if (entries[i] == v) begin
              hit = 1'b1;
              pos = i;
            end
          end
          if (hit) begin
            for (i = pos; i + 1 < held; i++) entries[i] = entries[i + 1];
            held--;
            st = STAT_OK;
          end else begin
            st = STAT_NOTFOUND;
          end
        end
        owe(v, st, 1'b1);
      end
      default: begin
        if (held == 0) begin
          owe('0, STAT_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < held; i++) begin
            pos = (item.op == OP_DUMP_FWD) ? i : held - 1 - i;
            owe(entries[pos], STAT_OK, i == held - 1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held       = 0;
      descending = 1'b0;
      owed_results.delete();
    end else begin
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 && paddr == ADDR_MODE) begin
        if (pwrite) begin
          descending = pwdata[0];
        end else if (prdata !== 32'(descending)) begin
          flag($sformatf("mode readback %h, expected %h", prdata, 32'(descending)));
        end
      end
      // Inputs first: a result accepted at the same edge belongs to an older item.
      if (start === 1'b1 && busy === 1'b0) predict_item(in_item);
      if (out_valid === 1'b1) begin
        if (owed_results.size() == 0) begin
          flag($sformatf("unexpected result value=%h occ=%0d status=%0d last=%0b",
                         out_item.entry_value, out_item.occupancy, out_item.status,
                         out_item.last));
        end else begin
          want = owed_results.pop_front();
          if (out_item.entry_value !== want.entry_value ||
              out_item.occupancy !== want.occupancy ||
              out_item.status !== want.status ||
              out_item.last !== want.last) begin
            flag($sformatf({"expected value=%h occ=%0d status=%0d last=%0b, ",
                            "got value=%h occ=%0d status=%0d last=%0b"},
                           want.entry_value, want.occupancy, want.status, want.last,
                           out_item.entry_value, out_item.occupancy, out_item.status,
                           out_item.last));
          end
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= owed_results.size();
    entries_held   <= held;
  end

endmodule

// File: tb/sorted_list_engine_tb.sv
// Testbench top of the sorted list engine: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module sorted_list_engine_tb;
  import sle_pkg::*;

  localparam int CAPACITY    = 16;
  // Watchdog bound on the run length.
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int results_owed;
  int entries_held;
  int cycle_count = 0;

  // When set, the sender issues items back to back with no idle cycles.
  logic   no_gaps = 1'b0;
  // Every value ever inserted and not yet deleted from here. It always holds at
  // least the stored entries, so deleting all of it empties the store.
  value_t live_values [$];
  // Ascending and descending phases, both orders repeated.
  logic   mode_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  sorted_list_engine_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .entries_held   (entries_held)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Operand values lean toward a few small numbers so that equal entries,
  // delete hits and ties in the insertion walk are common, with the extremes
  // and fully random patterns mixed in so every bit toggles.
  function automatic value_t pick_value();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        k = $urandom_range(0, 8);
        return value_t'(k - 4);
      end
      4, 5: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sh0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return value_t'($urandom());
    endcase
  endfunction

  // Offers one item after a random idle gap and returns at the edge that
  // accepts it. Start stays high on return so back-to-back items need no
  // second assignment in the same step.
  task automatic send_item(op_t code, value_t operand);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{op: code, value: operand};
    do @(posedge clk); while (busy);
    if (code == OP_INSERT) live_values.push_back(operand);
  endtask

  // Holds the sender off until every expected result has come and the block
  // reports idle. The first edge lets the checker's counters catch up.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 || busy) @(posedge clk);
  endtask

  // One APB transfer to the mode register: setup cycle, then access cycle
  // until pready. A read is checked by the checker against its own copy.
  task automatic mode_access(logic write, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_MODE;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int idx;
    int r;
    start   <= 1'b0;
    in_item <= '{op: OP_INSERT, value: '0};
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, ascending order.
    mode_access(1'b1, 32'd0);
    mode_access(1'b0, 32'd0);
    // Dumps and a delete on an empty store; dumps carry junk operands.
    send_item(OP_DUMP_FWD, '0);
    send_item(OP_DUMP_REV, 32'shdeadbeef);
    send_item(OP_DELETE, 32'sd123);
    // Deleting a sole entry must leave a clean empty store.
    send_item(OP_INSERT, '0);
    send_item(OP_DELETE, '0);
    send_item(OP_DUMP_FWD, '0);
    // Extremes of the value range, duplicates and near-zero neighbors.
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_DELETE, 32'sd42);
    send_item(OP_DELETE, '0);
    send_item(OP_DUMP_FWD, '0);
    send_item(OP_DUMP_REV, 32'shffffffff);
    // Flip the order while the store still holds entries; the walk keeps its
    // rule even though the stored order no longer matches.
    wait_idle();
    mode_access(1'b1, 32'd1);
    mode_access(1'b0, 32'd0);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 32'sd2);
    send_item(OP_DUMP_FWD, '0);

    // Random phases: each starts from an empty store with a fresh mode.
    for (int phase = 0; phase < 5; phase++) begin
      while (live_values.size() != 0) begin
        wait_idle();
        if (entries_held == 0) break;
        no_gaps = 1'b0;
        send_item(OP_DELETE, live_values.pop_front());
      end
      live_values.delete();
      wait_idle();
      mode_access(1'b1, {$urandom() & 32'hffff_fffe} | 32'(mode_plan[phase]));
      mode_access(1'b0, 32'd0);
      no_gaps = (phase == 2);

      // Fill past capacity so that inserts into a full store are exercised.
      for (int n = 0; n < 18; n++) begin
        if (n == 9) send_item(OP_DUMP_REV, value_t'($urandom()));
        send_item(OP_INSERT, pick_value());
      end
      send_item(OP_DUMP_FWD, value_t'($urandom()));

      // Mixed traffic; deletes mostly target values known to be stored.
      for (int n = 0; n < 10; n++) begin
        r = $urandom_range(0, 9);
        case (r)
          0, 1, 2, 3: send_item(OP_INSERT, pick_value());
          4, 5, 6: begin
            if (live_values.size() != 0 && $urandom_range(0, 9) < 7) begin
              idx = $urandom_range(0, live_values.size() - 1);
              send_item(OP_DELETE, live_values[idx]);
              live_values.delete(idx);
            end else begin
              send_item(OP_DELETE, pick_value());
            end
          end
          7: send_item(OP_DUMP_FWD, value_t'($urandom()));
          8: send_item(OP_DUMP_REV, value_t'($urandom()));
          default: begin
            wait_idle();
            send_item(OP_INSERT, pick_value());
          end
        endcase
      end
    end

    // Drain: all results in, block idle, then a short quiet stretch to catch
    // any stray result.
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
